// ===== design/dmpc_pkg.sv =====
// Shared types, codes and constants of the decimal magnitude and precision check.
`timescale 1ns / 1ps

package dmpc_pkg;

   // Field types of the result channel and the limit registers
   typedef logic signed [14:0] mag_type;
   typedef logic [7:0]         prec_type;
   typedef logic [1:0]         status_type;
   typedef logic [7:0]         char_type;

   // Result status codes
   localparam status_type STATUS_OK          = 2'd0;
   localparam status_type STATUS_OVERFLOW    = 2'd1;
   localparam status_type STATUS_UNDERFLOW   = 2'd2;
   localparam status_type STATUS_TOO_PRECISE = 2'd3;

   // Parse section codes
   localparam logic [1:0] SEC_SIGN = 2'd0;
   localparam logic [1:0] SEC_MANT = 2'd1;
   localparam logic [1:0] SEC_EXP  = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_MAX_MAGNITUDE = 2'd0;
   localparam logic [1:0] CSR_MIN_MAGNITUDE = 2'd1;
   localparam logic [1:0] CSR_MAX_PRECISION = 2'd2;

   // Limit reset values
   localparam mag_type  MAX_MAGNITUDE_RESET = 15'sd125;
   localparam mag_type  MIN_MAGNITUDE_RESET = -15'sd130;
   localparam prec_type MAX_PRECISION_RESET = 8'd38;

   // Forced magnitude for long or unparsable exponents
   localparam mag_type EXP_BIG     = 15'sd9999;
   localparam mag_type EXP_BIG_NEG = -15'sd9999;

   // Character codes
   localparam char_type CH_ZERO  = 8'h30;
   localparam char_type CH_NINE  = 8'h39;
   localparam char_type CH_PLUS  = 8'h2B;
   localparam char_type CH_MINUS = 8'h2D;
   localparam char_type CH_POINT = 8'h2E;
   localparam char_type CH_LOW_E = 8'h65;
   localparam char_type CH_UP_E  = 8'h45;

   // Parse state; all zero is the cleared state (section at sign position)
   typedef struct packed {
      logic [1:0]  section;
      logic        seen_point;
      logic        seen_significant;
      logic        sig_in_fraction;
      logic [9:0]  lead_count;
      logic [7:0]  digit_count;
      logic [8:0]  pending_zeros;
      logic [2:0]  exp_length;
      logic [13:0] exp_value;
      logic        exp_negative;
      logic        exp_has_digit;
      logic        exp_invalid;
   } parse_state_type;

   // Step control from the input stage
   typedef struct packed {
      logic go;
      logic last;
   } step_type;

   // Configured limits
   typedef struct packed {
      mag_type  max_magnitude;
      mag_type  min_magnitude;
      prec_type max_precision;
   } limits_type;

endpackage

// ===== design/dmpc_req_if.sv =====
// Character channel: valid, ready, character and last flag.
`timescale 1ns / 1ps

interface dmpc_req_if;
   logic                valid;
   logic                ready;
   dmpc_pkg::char_type  ch;
   logic                last;

   modport source (output valid, output ch, output last, input ready);
   modport sink   (input valid, input ch, input last, output ready);
endinterface

// ===== design/dmpc_rsp_if.sv =====
// Result channel: valid, ready, magnitude, precision and status.
`timescale 1ns / 1ps

interface dmpc_rsp_if;
   logic                  valid;
   logic                  ready;
   dmpc_pkg::mag_type     magnitude;
   dmpc_pkg::prec_type    precision;
   dmpc_pkg::status_type  status;

   modport source (output valid, output magnitude, output precision, output status,
                   input ready);
   modport sink   (input valid, input magnitude, input precision, input status,
                   output ready);
endinterface

// ===== design/dmpc_parse.sv =====
// Parse state register and its per-character update.
`timescale 1ns / 1ps

module dmpc_parse #(
   parameter int MAX_CHARS = 256,
   parameter int EXP_CHARS = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dmpc_pkg::step_type         step,
   input  dmpc_pkg::char_type         ch,
   output dmpc_pkg::parse_state_type  upd
);

   localparam int LeadCapInt = (MAX_CHARS < 1023) ? MAX_CHARS : 1023;
   localparam int PendCapInt = (MAX_CHARS < 511) ? MAX_CHARS : 511;
   localparam logic [9:0] LeadCap   = 10'(LeadCapInt);
   localparam logic [8:0] PendCap   = 9'(PendCapInt);
   localparam logic [2:0] ExpLenCap = 3'(EXP_CHARS + 1);
   localparam logic [2:0] ExpChars  = 3'(EXP_CHARS);

   dmpc_pkg::parse_state_type state_ff;
   dmpc_pkg::parse_state_type state_in;

   function automatic logic is_digit(input dmpc_pkg::char_type c);
      return (c >= dmpc_pkg::CH_ZERO) && (c <= dmpc_pkg::CH_NINE);
   endfunction

   // Apply one mantissa character
   function automatic dmpc_pkg::parse_state_type mant_char(
      input dmpc_pkg::parse_state_type s,
      input dmpc_pkg::char_type        c
   );
      dmpc_pkg::parse_state_type r;
      logic [7:0] diff;
      logic       nonzero;
      logic [9:0] total;
      r       = s;
      diff    = c - dmpc_pkg::CH_ZERO;
      nonzero = (diff[3:0] != 4'd0);
      total   = {2'b00, s.digit_count} + {1'b0, s.pending_zeros} + 10'd1;
      if (is_digit(c)) begin
         if (nonzero || s.seen_significant) begin
            if (!s.seen_significant) begin
               r.seen_significant = 1'b1;
               r.sig_in_fraction  = s.seen_point;
            end
            if (!s.seen_point && (s.lead_count < LeadCap)) begin
               r.lead_count = s.lead_count + 10'd1;
            end
            if (nonzero) begin
               r.digit_count   = (total > 10'd255) ? 8'd255 : total[7:0];
               r.pending_zeros = '0;
            end else if (s.pending_zeros < PendCap) begin
               r.pending_zeros = s.pending_zeros + 9'd1;
            end
         end else if (s.seen_point && (s.lead_count < LeadCap)) begin
            // leading zero after the point
            r.lead_count = s.lead_count + 10'd1;
         end
      end else if (c == dmpc_pkg::CH_POINT) begin
         r.seen_point = 1'b1;
      end else if ((c == dmpc_pkg::CH_LOW_E) || (c == dmpc_pkg::CH_UP_E)) begin
         r.section = dmpc_pkg::SEC_EXP;
      end
      return r;
   endfunction

   // Apply one exponent character
   function automatic dmpc_pkg::parse_state_type exp_char(
      input dmpc_pkg::parse_state_type s,
      input dmpc_pkg::char_type        c
   );
      dmpc_pkg::parse_state_type r;
      logic [7:0]  diff;
      logic [16:0] times_ten;
      r         = s;
      diff      = c - dmpc_pkg::CH_ZERO;
      times_ten = {s.exp_value, 3'b000} + {2'b00, s.exp_value, 1'b0}
                  + {13'd0, diff[3:0]};
      if (s.exp_length < ExpLenCap) begin
         r.exp_length = s.exp_length + 3'd1;
      end
      if (((c == dmpc_pkg::CH_MINUS) || (c == dmpc_pkg::CH_PLUS))
          && (s.exp_length == 3'd0)) begin
         r.exp_negative = (c == dmpc_pkg::CH_MINUS);
      end else if (is_digit(c)) begin
         r.exp_has_digit = 1'b1;
         if (s.exp_length < ExpChars) begin
            r.exp_value = times_ten[13:0];
         end
      end else begin
         r.exp_invalid = 1'b1;
      end
      return r;
   endfunction

   // Update the state by the current character
   always_comb begin
      upd = state_ff;
      unique case (state_ff.section)
         dmpc_pkg::SEC_SIGN: begin
            upd.section = dmpc_pkg::SEC_MANT;
            if ((ch != dmpc_pkg::CH_PLUS) && (ch != dmpc_pkg::CH_MINUS)) begin
               upd = mant_char(upd, ch);
            end
         end
         dmpc_pkg::SEC_MANT: begin
            upd = mant_char(state_ff, ch);
         end
         default: begin
            upd = exp_char(state_ff, ch);
         end
      endcase
   end

   // Clear after the final character, hold while idle
   always_comb begin
      state_in = state_ff;
      if (step.go) begin
         state_in = step.last ? '0 : upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/dmpc_result.sv =====
// Magnitude, precision and status from the final parse state, and the result register.
`timescale 1ns / 1ps

module dmpc_result #(
   parameter int EXP_CHARS = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dmpc_pkg::step_type         step,
   input  dmpc_pkg::parse_state_type  upd,
   input  dmpc_pkg::limits_type       limits,
   input  logic                       out_ready,
   output logic                       out_free,
   output logic                       out_valid,
   output dmpc_pkg::mag_type          out_magnitude,
   output dmpc_pkg::prec_type         out_precision,
   output dmpc_pkg::status_type       out_status
);

   localparam logic [2:0] ExpChars = 3'(EXP_CHARS);

   logic                  valid_ff;
   logic                  valid_in;
   dmpc_pkg::mag_type     magnitude_ff;
   dmpc_pkg::prec_type    precision_ff;
   dmpc_pkg::status_type  status_ff;

   dmpc_pkg::mag_type     lead_s;
   dmpc_pkg::mag_type     exp_s;
   dmpc_pkg::mag_type     mag;
   dmpc_pkg::prec_type    prec;
   dmpc_pkg::status_type  status;

   // Mantissa magnitude, then the exponent where digits are significant
   always_comb begin
      lead_s = signed'({5'b00000, upd.lead_count});
      exp_s  = signed'({1'b0, upd.exp_value});
      mag    = '0;
      prec   = '0;
      if (upd.seen_significant) begin
         prec = upd.digit_count;
         mag  = upd.sig_in_fraction ? (-lead_s - 15'sd1) : (lead_s - 15'sd1);
      end
      if ((prec != 8'd0) && (upd.section == dmpc_pkg::SEC_EXP)) begin
         priority if (upd.exp_length > ExpChars) begin
            mag = upd.exp_negative ? dmpc_pkg::EXP_BIG_NEG : dmpc_pkg::EXP_BIG;
         end else if (upd.exp_invalid || !upd.exp_has_digit) begin
            mag = dmpc_pkg::EXP_BIG;
         end else if (upd.exp_negative) begin
            mag = mag - exp_s;
         end else begin
            mag = mag + exp_s;
         end
      end
   end

   // Check against the limits: overflow first, then underflow, then precision
   always_comb begin
      priority if (mag > limits.max_magnitude) begin
         status = dmpc_pkg::STATUS_OVERFLOW;
      end else if (mag < limits.min_magnitude) begin
         status = dmpc_pkg::STATUS_UNDERFLOW;
      end else if (prec > limits.max_precision) begin
         status = dmpc_pkg::STATUS_TOO_PRECISE;
      end else begin
         status = dmpc_pkg::STATUS_OK;
      end
   end

   assign out_free = !valid_ff || out_ready;

   // Load on the final character, drop after the transfer
   always_comb begin
      valid_in = valid_ff;
      if (step.go && step.last) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step.go && step.last) begin
         magnitude_ff <= mag;
         precision_ff <= prec;
         status_ff    <= status;
      end
   end

   assign out_valid     = valid_ff;
   assign out_magnitude = magnitude_ff;
   assign out_precision = precision_ff;
   assign out_status    = status_ff;

endmodule

// ===== design/decimal_magnitude_precision_check.sv =====
// Top level: input register, parse state, result register and limit registers.
// A result: the final character passes the input register, then loads the result register.
// Throughput: one character per cycle; the input register feeds the registered parse
//    state, and only a final character waits on a full result register.
// Reset (synchronous, active high) empties both registers, clears the parse
//    state and loads the limits with 125, -130 and 38.
`timescale 1ns / 1ps

module decimal_magnitude_precision_check #(
   parameter int MAX_CHARS = 256,
   parameter int EXP_CHARS = 4
) (
   input  logic                clock,
   input  logic                reset,
   dmpc_req_if.sink            req_chan,
   dmpc_rsp_if.source          rsp_chan,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [14:0]         csr_wdata
);

   logic                       in_valid_ff;
   logic                       in_valid_in;
   dmpc_pkg::char_type         in_ch_ff;
   logic                       in_last_ff;
   logic                       in_go;
   logic                       out_free;
   dmpc_pkg::step_type         step;
   dmpc_pkg::parse_state_type  upd;
   dmpc_pkg::limits_type       limits_ff;

   // Input stage moves on unless a final character meets a full result register
   assign in_go          = in_valid_ff && (!in_last_ff || out_free);
   assign req_chan.ready = !in_valid_ff || in_go;
   assign step.go        = in_go;
   assign step.last      = in_last_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_ch_ff   <= req_chan.ch;
         in_last_ff <= req_chan.last;
      end
   end

   // Limit registers; an index beyond the list is ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.max_magnitude <= dmpc_pkg::MAX_MAGNITUDE_RESET;
         limits_ff.min_magnitude <= dmpc_pkg::MIN_MAGNITUDE_RESET;
         limits_ff.max_precision <= dmpc_pkg::MAX_PRECISION_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            dmpc_pkg::CSR_MAX_MAGNITUDE: limits_ff.max_magnitude <= signed'(csr_wdata);
            dmpc_pkg::CSR_MIN_MAGNITUDE: limits_ff.min_magnitude <= signed'(csr_wdata);
            dmpc_pkg::CSR_MAX_PRECISION: limits_ff.max_precision <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   dmpc_parse #(
      .MAX_CHARS (MAX_CHARS),
      .EXP_CHARS (EXP_CHARS)
   ) u_parse (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .ch    (in_ch_ff),
      .upd   (upd)
   );

   dmpc_result #(
      .EXP_CHARS (EXP_CHARS)
   ) u_result (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .upd           (upd),
      .limits        (limits_ff),
      .out_ready     (rsp_chan.ready),
      .out_free      (out_free),
      .out_valid     (rsp_chan.valid),
      .out_magnitude (rsp_chan.magnitude),
      .out_precision (rsp_chan.precision),
      .out_status    (rsp_chan.status)
   );

endmodule

// ===== design/dmpc_checker.sv =====
// Port-level assertions for the decimal magnitude and precision check, with its bind.
`timescale 1ns / 1ps

module dmpc_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input dmpc_pkg::mag_type     rsp_magnitude,
   input dmpc_pkg::prec_type    rsp_precision,
   input dmpc_pkg::status_type  rsp_status
);

   // Reset empties the result register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Hold a stalled result and its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_magnitude)
         && $stable(rsp_precision) && $stable(rsp_status))
      else $error("stalled result changed");

   // No significant digit means magnitude zero
   a_zero_mag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_precision == 8'd0) |-> (rsp_magnitude == 15'sd0))
      else $error("nonzero magnitude without significant digits");

   // Too precise needs at least one digit
   a_precise: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == dmpc_pkg::STATUS_TOO_PRECISE)
         |-> (rsp_precision != 8'd0))
      else $error("too precise status with no digits");

endmodule

bind decimal_magnitude_precision_check dmpc_checker u_dmpc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_magnitude (rsp_chan.magnitude),
   .rsp_precision (rsp_chan.precision),
   .rsp_status    (rsp_chan.status)
);

// ===== tb/dmpc_tb_pkg.sv =====
// Scoreboard for the decimal magnitude and precision check: limits, parse predictor, results.
`timescale 1ns / 1ps

package dmpc_tb_pkg;

   // Block parameters as instantiated by the testbench
   localparam int MAX_CHARS   = 256;
   localparam int EXP_CHARS   = 4;
   localparam int LEAD_CAP    = (MAX_CHARS < 1023) ? MAX_CHARS : 1023;
   localparam int PEND_CAP    = (MAX_CHARS < 511) ? MAX_CHARS : 511;
   localparam int EXP_LEN_CAP = EXP_CHARS + 1;

   // Register index past the end of the list; writes to it are dropped
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      dmpc_pkg::mag_type    magnitude;
      dmpc_pkg::prec_type   precision;
      dmpc_pkg::status_type status;
   } measure_type;

   class scoreboard_type;
      int                        mismatches;
      int                        max_mag;
      int                        min_mag;
      int                        max_prec;
      dmpc_pkg::parse_state_type ps;
      measure_type               measure_q[$];

      function new();
         mismatches = 0;
         max_mag    = dmpc_pkg::MAX_MAGNITUDE_RESET;
         min_mag    = dmpc_pkg::MIN_MAGNITUDE_RESET;
         max_prec   = dmpc_pkg::MAX_PRECISION_RESET;
         ps         = '0;
      endfunction

      function void set_limit(logic [1:0] idx, logic [14:0] data);
         case (idx)
            dmpc_pkg::CSR_MAX_MAGNITUDE: max_mag = $signed(data);
            dmpc_pkg::CSR_MIN_MAGNITUDE: min_mag = $signed(data);
            dmpc_pkg::CSR_MAX_PRECISION: max_prec = int'(data[7:0]);
            default: ;
         endcase
      endfunction

      function int pending();
         return measure_q.size();
      endfunction

      // Mantissa: digits, point, exponent marker; everything else is dropped
      function void mantissa_char(dmpc_pkg::char_type c);
         logic [7:0] d;
         int         n;
         if (c >= dmpc_pkg::CH_ZERO && c <= dmpc_pkg::CH_NINE) begin
            d = c - dmpc_pkg::CH_ZERO;
            if (d != 0 || ps.seen_significant) begin
               if (!ps.seen_significant) begin
                  ps.seen_significant = 1'b1;
                  ps.sig_in_fraction  = ps.seen_point;
               end
               if (!ps.seen_point && ps.lead_count < LEAD_CAP)
                  ps.lead_count = ps.lead_count + 10'd1;
               if (d != 0) begin
                  n = int'(ps.digit_count) + int'(ps.pending_zeros) + 1;
                  ps.digit_count   = (n > 255) ? 8'd255 : 8'(n);
                  ps.pending_zeros = '0;
               end else if (ps.pending_zeros < PEND_CAP) begin
                  ps.pending_zeros = ps.pending_zeros + 9'd1;
               end
            end else if (ps.seen_point && ps.lead_count < LEAD_CAP) begin
               ps.lead_count = ps.lead_count + 10'd1;
            end
         end else if (c == dmpc_pkg::CH_POINT) begin
            ps.seen_point = 1'b1;
         end else if (c == dmpc_pkg::CH_LOW_E || c == dmpc_pkg::CH_UP_E) begin
            ps.section = dmpc_pkg::SEC_EXP;
         end
      endfunction

      // Exponent: sign only in first place, at most EXP_CHARS digits accumulated
      function void exponent_char(dmpc_pkg::char_type c);
         int pos;
         pos = int'(ps.exp_length);
         if (ps.exp_length < EXP_LEN_CAP)
            ps.exp_length = ps.exp_length + 3'd1;
         if ((c == dmpc_pkg::CH_MINUS || c == dmpc_pkg::CH_PLUS) && pos == 0) begin
            ps.exp_negative = (c == dmpc_pkg::CH_MINUS);
         end else if (c >= dmpc_pkg::CH_ZERO && c <= dmpc_pkg::CH_NINE) begin
            ps.exp_has_digit = 1'b1;
            if (pos < EXP_CHARS)
               ps.exp_value = ps.exp_value * 14'd10 + 14'(c - dmpc_pkg::CH_ZERO);
         end else begin
            ps.exp_invalid = 1'b1;
         end
      endfunction

      // Advance the parse on one transfer; on the final character queue the measure
      function void take_char(dmpc_pkg::char_type c, logic is_last);
         int          mag;
         int          prec;
         measure_type m;
         if (ps.section == dmpc_pkg::SEC_SIGN) begin
            ps.section = dmpc_pkg::SEC_MANT;
            if (c != dmpc_pkg::CH_PLUS && c != dmpc_pkg::CH_MINUS)
               mantissa_char(c);
         end else if (ps.section == dmpc_pkg::SEC_MANT) begin
            mantissa_char(c);
         end else begin
            exponent_char(c);
         end
         if (!is_last)
            return;

         mag  = 0;
         prec = 0;
         if (ps.seen_significant) begin
            prec = int'(ps.digit_count);
            mag  = ps.sig_in_fraction ? -int'(ps.lead_count) - 1 : int'(ps.lead_count) - 1;
         end
         // Exponent counts only when there is a significant digit
         if (prec != 0 && ps.section == dmpc_pkg::SEC_EXP) begin
            if (ps.exp_length > EXP_CHARS)
               mag = ps.exp_negative ? int'(dmpc_pkg::EXP_BIG_NEG) : int'(dmpc_pkg::EXP_BIG);
            else if (ps.exp_invalid || !ps.exp_has_digit)
               mag = int'(dmpc_pkg::EXP_BIG);
            else if (ps.exp_negative)
               mag = mag - int'(ps.exp_value);
            else
               mag = mag + int'(ps.exp_value);
         end

         m.magnitude = dmpc_pkg::mag_type'(mag);
         m.precision = dmpc_pkg::prec_type'(prec);
         if (mag > max_mag)
            m.status = dmpc_pkg::STATUS_OVERFLOW;
         else if (mag < min_mag)
            m.status = dmpc_pkg::STATUS_UNDERFLOW;
         else if (prec > max_prec)
            m.status = dmpc_pkg::STATUS_TOO_PRECISE;
         else
            m.status = dmpc_pkg::STATUS_OK;
         measure_q.insert(measure_q.size(), m);
         ps = '0;
      endfunction

      task report(string msg);
         $display("%0t ns: mismatch: %s", $time, msg);
         mismatches++;
      endtask

      // Compare one result transfer with the oldest queued measure
      task check_measure(dmpc_pkg::mag_type mag, dmpc_pkg::prec_type prec,
                         dmpc_pkg::status_type st);
         measure_type want;
         if (measure_q.size() == 0) begin
            report($sformatf("unexpected result magnitude %0d precision %0d status %0d",
                             mag, prec, st));
            return;
         end
         want = measure_q.pop_front();
         if (mag !== want.magnitude)
            report($sformatf("magnitude %0d, expected %0d", mag, want.magnitude));
         if (prec !== want.precision)
            report($sformatf("precision %0d, expected %0d", prec, want.precision));
         if (st !== want.status)
            report($sformatf("status %0d, expected %0d", st, want.status));
      endtask
   endclass

endpackage

// ===== tb/decimal_magnitude_precision_check_tb.sv =====
// Testbench top: drives number strings through the check and scores every result.
`timescale 1ns / 1ps

module decimal_magnitude_precision_check_tb;

   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 6;
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 270;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [14:0] csr_wdata;

   dmpc_req_if req ();
   dmpc_rsp_if rsp ();

   dmpc_tb_pkg::scoreboard_type sb;
   dmpc_pkg::char_type          word[$];
   int                          burst_left = 0;
   int                          idle_cycles = 0;

   decimal_magnitude_precision_check #(
      .MAX_CHARS(dmpc_tb_pkg::MAX_CHARS),
      .EXP_CHARS(dmpc_tb_pkg::EXP_CHARS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req),
      .rsp_chan  (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Drive one character; open a gap whenever the current burst is used up
   task automatic send_char(input dmpc_pkg::char_type c, input logic is_last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 4);
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 12);
      end
      req.valid <= 1'b1;
      req.ch    <= c;
      req.last  <= is_last;
      do @(posedge clock); while (req.ready !== 1'b1);
      sb.take_char(c, is_last);
      burst_left--;
   endtask

   task automatic send_word();
      int i;
      for (i = 0; i < word.size(); i++)
         send_char(word[i], i == word.size() - 1);
   endtask

   // Append one character to the string under construction
   function automatic void add_char(input dmpc_pkg::char_type c);
      word.insert(word.size(), c);
   endfunction

   task automatic send_text(input string s);
      int i;
      word.delete();
      for (i = 0; i < s.len(); i++)
         add_char(dmpc_pkg::char_type'(s[i]));
      send_word();
   endtask

   function automatic dmpc_pkg::char_type digit_char(input int zero_pct);
      if ($urandom_range(0, 99) < zero_pct)
         return dmpc_pkg::CH_ZERO;
      return dmpc_pkg::char_type'(dmpc_pkg::CH_ZERO + $urandom_range(0, 9));
   endfunction

   function automatic dmpc_pkg::char_type special_char();
      case ($urandom_range(0, 5))
         0: return dmpc_pkg::CH_PLUS;
         1: return dmpc_pkg::CH_MINUS;
         2: return dmpc_pkg::CH_POINT;
         3: return dmpc_pkg::CH_LOW_E;
         4: return dmpc_pkg::CH_UP_E;
         default: return digit_char(30);
      endcase
   endfunction

   function automatic void push_sign();
      case ($urandom_range(0, 2))
         1: add_char(dmpc_pkg::CH_PLUS);
         2: add_char(dmpc_pkg::CH_MINUS);
         default: ;
      endcase
   endfunction

   function automatic void push_exponent(input int max_digits);
      int n;
      int i;
      add_char($urandom_range(0, 1) ? dmpc_pkg::CH_LOW_E : dmpc_pkg::CH_UP_E);
      push_sign();
      n = ($urandom_range(0, 4) == 0)
          ? $urandom_range(dmpc_tb_pkg::EXP_CHARS + 1, dmpc_tb_pkg::EXP_CHARS + 2)
          : $urandom_range(0, max_digits);
      for (i = 0; i < n; i++)
         add_char(digit_char(10));
   endfunction

   // Build one number string: mostly well formed, some dense, noisy, broken or long
   function automatic void build_number();
      int kind;
      int n;
      int i;
      int pos;
      word.delete();
      kind = $urandom_range(0, 99);
      if (kind < 60 || (kind >= 88 && kind < 96)) begin
         push_sign();
         n = $urandom_range(0, 6);
         for (i = 0; i < n; i++)
            add_char(digit_char(35));
         if ($urandom_range(0, 1)) begin
            add_char(dmpc_pkg::CH_POINT);
            n = $urandom_range(0, 6);
            for (i = 0; i < n; i++)
               add_char(digit_char(35));
         end
         if ($urandom_range(0, 2) != 0)
            push_exponent(dmpc_tb_pkg::EXP_CHARS);
         if (word.size() == 0)
            add_char(digit_char(50));
         // Corrupt one position: overwrite it or insert a stray byte
         if (kind >= 88) begin
            pos = $urandom_range(0, word.size() - 1);
            if ($urandom_range(0, 1))
               word[pos] = dmpc_pkg::char_type'($urandom_range(0, 255));
            else
               word.insert(pos, dmpc_pkg::char_type'($urandom_range(0, 255)));
         end
      end else if (kind < 75) begin
         push_sign();
         n   = $urandom_range(30, 45);
         pos = $urandom_range(0, n);
         for (i = 0; i < n; i++) begin
            if (i == pos)
               add_char(dmpc_pkg::CH_POINT);
            add_char(digit_char(20));
         end
         if ($urandom_range(0, 1))
            push_exponent(2);
      end else if (kind < 88) begin
         n = $urandom_range(1, 8);
         for (i = 0; i < n; i++)
            add_char($urandom_range(0, 1) ? dmpc_pkg::char_type'($urandom_range(0, 255))
                                          : special_char());
      end else begin
         // Long strings that saturate the lead, pending and digit counters
         n = $urandom_range(dmpc_tb_pkg::MAX_CHARS + 1, dmpc_tb_pkg::MAX_CHARS + 24);
         case ($urandom_range(0, 2))
            0: begin
               add_char(dmpc_pkg::char_type'(dmpc_pkg::CH_ZERO + $urandom_range(1, 9)));
               for (i = 0; i < n; i++)
                  add_char(digit_char(30));
            end
            1: begin
               add_char(dmpc_pkg::CH_ZERO);
               add_char(dmpc_pkg::CH_POINT);
               for (i = 0; i < n; i++)
                  add_char(dmpc_pkg::CH_ZERO);
               add_char(dmpc_pkg::char_type'(dmpc_pkg::CH_ZERO + $urandom_range(1, 9)));
            end
            default: begin
               add_char(dmpc_pkg::char_type'(dmpc_pkg::CH_ZERO + $urandom_range(1, 9)));
               for (i = 0; i < n; i++)
                  add_char(dmpc_pkg::CH_ZERO);
               add_char(dmpc_pkg::char_type'(dmpc_pkg::CH_ZERO + $urandom_range(1, 9)));
               add_char(dmpc_pkg::CH_POINT);
               add_char(digit_char(30));
            end
         endcase
         if ($urandom_range(0, 1))
            push_exponent(dmpc_tb_pkg::EXP_CHARS);
      end
   endfunction

   // Hold the input low until every result is back, then let the pipeline settle
   task automatic drain();
      req.valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic put_csr(input logic [1:0] idx, input logic [14:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.set_limit(idx, data);
   endtask

   // Write the three limits, plus a dropped write past the register list
   task automatic write_limits(input int mx, input int mn, input int pr);
      put_csr(dmpc_tb_pkg::CSR_UNUSED, 15'($urandom));
      put_csr(dmpc_pkg::CSR_MAX_MAGNITUDE, 15'(mx));
      put_csr(dmpc_pkg::CSR_MIN_MAGNITUDE, 15'(mn));
      put_csr(dmpc_pkg::CSR_MAX_PRECISION, {7'($urandom), 8'(pr)});
      csr_we <= 1'b0;
   endtask

   task automatic set_phase_limits(input int phase);
      case (phase)
         1: write_limits(16383, -16384, 255);
         2: write_limits(-16384, 16383, 0);
         3: write_limits(0, 0, 38);
         4: write_limits(int'($urandom_range(0, 32767)) - 16384,
                         int'($urandom_range(0, 32767)) - 16384, $urandom_range(0, 255));
         default: write_limits(int'($urandom_range(0, 300)) - 50,
                               int'($urandom_range(0, 300)) - 250, $urandom_range(0, 50));
      endcase
   endtask

   // Result side: score transfers and stall on a pattern that is picked anew at random
   initial begin : result_side
      int mode;
      int stall_left;
      int cycle;
      mode       = 0;
      stall_left = 0;
      cycle      = 0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid === 1'b1 && rsp.ready === 1'b1)
            sb.check_measure(rsp.magnitude, rsp.precision, rsp.status);
         cycle++;
         if (cycle % 64 == 0)
            mode = $urandom_range(0, 2);
         case (mode)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= ($urandom_range(0, 3) != 0);
            default: begin
               if (stall_left > 0) begin
                  stall_left--;
                  rsp.ready <= 1'b0;
               end else begin
                  rsp.ready <= 1'b1;
                  if ($urandom_range(0, 3) == 0)
                     stall_left = $urandom_range(1, 12);
               end
            end
         endcase
      end
   end

   // Watchdog: end the run when no transfer happens for too long
   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req.valid === 1'b1 && req.ready === 1'b1) ||
             (rsp.valid === 1'b1 && rsp.ready === 1'b1))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("decimal_magnitude_precision_check_tb: FAIL");
      $finish;
   end

   initial begin : stimulus
      int phase;
      int items;
      sb = new();
      reset     <= 1'b1;
      csr_we    <= 1'b0;
      csr_index <= dmpc_pkg::CSR_MAX_MAGNITUDE;
      csr_wdata <= '0;
      req.valid <= 1'b0;
      req.ch    <= '0;
      req.last  <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero mantissa with ignored exponent, long negative exponent,
      // misplaced exponent sign, stray mantissa characters, lone exponent marker
      send_text("-0e5");
      send_text("1e-12345");
      send_text("5e1-");
      send_text("1.2.0x-9");
      send_text("E");

      // Random phases, each under its own limits
      items = 0;
      for (phase = 0; phase < PHASES; phase++) begin
         if (phase > 0)
            set_phase_limits(phase);
         while (items < (phase + 1) * PHASE_ITEMS) begin
            build_number();
            send_word();
            items += word.size();
         end
         drain();
      end

      if (sb.pending() != 0)
         sb.report($sformatf("%0d results never arrived", sb.pending()));
      if (sb.mismatches == 0)
         $display("decimal_magnitude_precision_check_tb: PASS");
      else
         $display("decimal_magnitude_precision_check_tb: FAIL");
      $finish;
   end

endmodule

// ===== decimal_magnitude_precision_check.f =====
design/dmpc_pkg.sv
design/dmpc_req_if.sv
design/dmpc_rsp_if.sv
design/dmpc_parse.sv
design/dmpc_result.sv
design/decimal_magnitude_precision_check.sv
design/dmpc_checker.sv
tb/dmpc_tb_pkg.sv
tb/decimal_magnitude_precision_check_tb.sv
